>>> hdl/spd_pkg.sv
// shared types and constants for the sensor packet deframer
package spd_pkg;

  // default number of address bytes skipped after the start code
  localparam int unsigned ADDR_BYTES_DEF = 4;

  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned OUT_DW    = 56;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_START_CODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CAPACITY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT    = 2'd2;

  localparam logic [15:0] START_CODE_RST = 16'hEF01;
  localparam logic [15:0] CAPACITY_RST   = 16'd256;
  localparam logic [15:0] TIMEOUT_RST    = 16'd2500;
  localparam logic [15:0] GAP_MAX        = 16'hFFFF;

  // end of frame status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_OVERFLOW = 3'd2;
  localparam logic [2:0] ST_CSUM     = 3'd3;
  localparam logic [2:0] ST_TIMEOUT  = 3'd4;

  // result kinds
  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_STATUS = 1'b1;

  // input item kinds
  localparam logic FUNC_BYTE = 1'b0;
  localparam logic FUNC_TICK = 1'b1;

  typedef enum logic [8:0] {
    PH_HUNT_HI = 9'b000000001,
    PH_HUNT_LO = 9'b000000010,
    PH_ADDR    = 9'b000000100,
    PH_TYPE    = 9'b000001000,
    PH_LEN_HI  = 9'b000010000,
    PH_LEN_LO  = 9'b000100000,
    PH_DATA    = 9'b001000000,
    PH_CS_HI   = 9'b010000000,
    PH_CS_LO   = 9'b100000000
  } phase_t;

  typedef struct packed {
    logic [15:0] start_code;
    logic [15:0] capacity;
    logic [15:0] timeout;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] frame_length;
    logic [7:0]  frame_type;
    logic [15:0] byte_index;
    logic [7:0]  payload_byte;
    logic        kind;
  } result_t;

endpackage

>>> hdl/spd_cfg_regs.sv
// configuration register bank of the deframer
module spd_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spd_pkg::CFG_W-1:0]     cfg_wdata,
  output spd_pkg::cfg_t                 cfg
);

  spd_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        spd_pkg::REG_START_CODE: cfg_nxt.start_code = cfg_wdata;
        spd_pkg::REG_CAPACITY:   cfg_nxt.capacity   = cfg_wdata;
        spd_pkg::REG_TIMEOUT:    cfg_nxt.timeout    = cfg_wdata;
        default:                 cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_code <= spd_pkg::START_CODE_RST;
      cfg_r.capacity   <= spd_pkg::CAPACITY_RST;
      cfg_r.timeout    <= spd_pkg::TIMEOUT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

>>> hdl/spd_in_stage.sv
// input register stage of the deframer
module spd_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       in_tuser,
  input  logic       advance,
  output logic       item_valid,
  output logic       item_func,
  output logic [7:0] item_byte
);

  logic       vld_r, vld_nxt;
  logic       func_r;
  logic [7:0] byte_r;
  logic       take;

  assign in_tready = !vld_r || advance;
  assign take      = in_tvalid && in_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (take)         vld_nxt = 1'b1;
    else if (advance) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      func_r <= in_tuser;
      byte_r <= in_tdata;
    end
  end

  assign item_valid = vld_r;
  assign item_func  = func_r;
  assign item_byte  = byte_r;

endmodule

>>> hdl/spd_parser.sv
// frame parser: phase machine, counters, checksum and gap timer
module spd_parser #(
  parameter int unsigned ADDR_BYTES = spd_pkg::ADDR_BYTES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  logic             item_func,
  input  logic [7:0]       item_byte,
  input  spd_pkg::cfg_t    cfg,
  output logic             res_valid,
  output spd_pkg::result_t res
);

  localparam logic [15:0] ADDR_LAST = 16'(ADDR_BYTES);

  spd_pkg::phase_t phase_r, phase_nxt;
  logic [15:0] fc_r, fc_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] len_r, len_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  cs_hi_r, cs_hi_nxt;
  logic        ovf_r, ovf_nxt;
  logic [15:0] gap_r, gap_nxt;

  logic        clr;
  logic [15:0] fc_inc;
  logic [15:0] sum_add;
  logic [15:0] gap_inc;
  logic [15:0] wire_len;
  logic [15:0] pay_len;

  assign fc_inc   = fc_r + 16'd1;
  assign sum_add  = sum_r + {8'd0, item_byte};
  assign gap_inc  = (gap_r == spd_pkg::GAP_MAX) ? gap_r : gap_r + 16'd1;
  assign wire_len = {len_r[15:8], item_byte};
  assign pay_len  = wire_len - 16'd2;

  always_comb begin
    phase_nxt = phase_r;
    fc_nxt    = fc_r;
    type_nxt  = type_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    cs_hi_nxt = cs_hi_r;
    ovf_nxt   = ovf_r;
    gap_nxt   = gap_r;
    clr       = 1'b0;
    res_valid = 1'b0;
    res       = '0;

    if (item_func == spd_pkg::FUNC_TICK) begin
      // ticks only count while a frame is under way
      if (phase_r != spd_pkg::PH_HUNT_HI) begin
        gap_nxt = gap_inc;
        if (gap_inc >= cfg.timeout) begin
          res_valid   = 1'b1;
          res.kind    = spd_pkg::KIND_STATUS;
          res.status  = spd_pkg::ST_TIMEOUT;
          res.frame_type = type_r;
          if (phase_r == spd_pkg::PH_DATA || phase_r == spd_pkg::PH_CS_HI ||
              phase_r == spd_pkg::PH_CS_LO) begin
            res.frame_length = len_r;
          end
          clr = 1'b1;
        end
      end
    end else begin
      gap_nxt = '0;
      case (phase_r)
        spd_pkg::PH_HUNT_HI: begin
          if (item_byte == cfg.start_code[15:8]) phase_nxt = spd_pkg::PH_HUNT_LO;
        end
        spd_pkg::PH_HUNT_LO: begin
          // a wrong second byte is not rechecked as a first byte
          if (item_byte == cfg.start_code[7:0]) begin
            fc_nxt    = '0;
            phase_nxt = (ADDR_BYTES > 0) ? spd_pkg::PH_ADDR : spd_pkg::PH_TYPE;
          end else begin
            phase_nxt = spd_pkg::PH_HUNT_HI;
          end
        end
        spd_pkg::PH_ADDR: begin
          fc_nxt = fc_inc;
          if (fc_inc >= ADDR_LAST) begin
            fc_nxt    = '0;
            phase_nxt = spd_pkg::PH_TYPE;
          end
        end
        spd_pkg::PH_TYPE: begin
          type_nxt  = item_byte;
          sum_nxt   = {8'd0, item_byte};
          phase_nxt = spd_pkg::PH_LEN_HI;
        end
        spd_pkg::PH_LEN_HI: begin
          len_nxt   = {item_byte, 8'd0};
          sum_nxt   = sum_add;
          phase_nxt = spd_pkg::PH_LEN_LO;
        end
        spd_pkg::PH_LEN_LO: begin
          sum_nxt = sum_add;
          if (wire_len < 16'd2) begin
            res_valid      = 1'b1;
            res.kind       = spd_pkg::KIND_STATUS;
            res.status     = spd_pkg::ST_SHORT;
            res.frame_type = type_r;
            clr            = 1'b1;
          end else begin
            len_nxt   = pay_len;
            fc_nxt    = '0;
            ovf_nxt   = pay_len > cfg.capacity;
            phase_nxt = (pay_len == 16'd0) ? spd_pkg::PH_CS_HI : spd_pkg::PH_DATA;
          end
        end
        spd_pkg::PH_DATA: begin
          sum_nxt = sum_add;
          fc_nxt  = fc_inc;
          if (fc_inc >= len_r) phase_nxt = spd_pkg::PH_CS_HI;
          // oversized frames are consumed silently
          if (!ovf_r) begin
            res_valid        = 1'b1;
            res.kind         = spd_pkg::KIND_DATA;
            res.payload_byte = item_byte;
            res.byte_index   = fc_r;
            res.frame_type   = type_r;
            res.frame_length = len_r;
            res.status       = spd_pkg::ST_OK;
          end
        end
        spd_pkg::PH_CS_HI: begin
          cs_hi_nxt = item_byte;
          phase_nxt = spd_pkg::PH_CS_LO;
        end
        spd_pkg::PH_CS_LO: begin
          res_valid        = 1'b1;
          res.kind         = spd_pkg::KIND_STATUS;
          res.frame_type   = type_r;
          res.frame_length = len_r;
          if (ovf_r)                                res.status = spd_pkg::ST_OVERFLOW;
          else if ({cs_hi_r, item_byte} != sum_r)   res.status = spd_pkg::ST_CSUM;
          else                                      res.status = spd_pkg::ST_OK;
          clr = 1'b1;
        end
        default: clr = 1'b1;
      endcase
    end

    if (clr) begin
      phase_nxt = spd_pkg::PH_HUNT_HI;
      fc_nxt    = '0;
      type_nxt  = '0;
      len_nxt   = '0;
      sum_nxt   = '0;
      cs_hi_nxt = '0;
      ovf_nxt   = 1'b0;
      gap_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= spd_pkg::PH_HUNT_HI;
      fc_r    <= '0;
      type_r  <= '0;
      len_r   <= '0;
      sum_r   <= '0;
      cs_hi_r <= '0;
      ovf_r   <= 1'b0;
      gap_r   <= '0;
    end else if (advance) begin
      phase_r <= phase_nxt;
      fc_r    <= fc_nxt;
      type_r  <= type_nxt;
      len_r   <= len_nxt;
      sum_r   <= sum_nxt;
      cs_hi_r <= cs_hi_nxt;
      ovf_r   <= ovf_nxt;
      gap_r   <= gap_nxt;
    end
  end

endmodule

>>> hdl/spd_out_stage.sv
// result register stage of the deframer
module spd_out_stage (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       load,
  input  spd_pkg::result_t           res,
  output logic                       space,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [spd_pkg::OUT_DW-1:0] out_tdata,
  output logic                       out_tuser
);

  localparam int unsigned PAD_W = spd_pkg::OUT_DW - ($bits(spd_pkg::result_t) - 1);

  logic             vld_r, vld_nxt;
  spd_pkg::result_t res_r;

  assign space = !vld_r || out_tready;

  always_comb begin
    vld_nxt = vld_r;
    if (load)            vld_nxt = 1'b1;
    else if (out_tready) vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) res_r <= res;
  end

  assign out_tvalid = vld_r;
  assign out_tuser  = res_r.kind;
  assign out_tdata  = {{PAD_W{1'b0}}, res_r.status, res_r.frame_length, res_r.frame_type,
                       res_r.byte_index, res_r.payload_byte};

endmodule

>>> hdl/sensor_packet_deframer_unit.sv
// top level of the sensor packet deframer
//
//  port group  dir  payload
//  in_         in   tdata: rx_byte[7:0]; tuser: func (0 byte, 1 tick)
//  out_        out  tdata: payload_byte, byte_index, frame_type, frame_length, status
//                   tuser: kind (0 payload byte, 1 end of frame status)
//  cfg_        in   index 0 start_code, 1 payload_capacity, 2 byte_timeout_ticks
//
// one input transaction per cycle unless the parser step waits; each one is parsed
// from the input register, and its result is registered in the result stage
// a transaction gives at most one result; the parser step waits only when the
// result register is still full and out_tready is low
// rst_n (synchronous) returns the parser to start code hunting and the
// registers to their defaults; configuration writes take effect on the next edge
module sensor_packet_deframer_unit #(
  parameter int unsigned ADDR_BYTES = spd_pkg::ADDR_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [7:0]                    in_tdata,   // rx_byte[7:0]
  input  logic                          in_tuser,   // func[0]
  // result channel
  output logic                          out_tvalid,
  input  logic                          out_tready,
  // payload_byte[7:0], byte_index[23:8], frame_type[31:24],
  // frame_length[47:32], status[50:48], zero pad[55:51]
  output logic [spd_pkg::OUT_DW-1:0]    out_tdata,
  output logic                          out_tuser,  // kind[0]
  // configuration port
  input  logic                          cfg_we,
  input  logic [spd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [spd_pkg::CFG_W-1:0]     cfg_wdata
);

  spd_pkg::cfg_t    cfg;
  spd_pkg::result_t res;
  logic             item_valid;
  logic             item_func;
  logic [7:0]       item_byte;
  logic             res_valid;
  logic             space;
  logic             advance;

  // parse the held transaction once the result side can take its result
  assign advance = item_valid && space;

  spd_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  spd_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .advance    (advance),
    .item_valid (item_valid),
    .item_func  (item_func),
    .item_byte  (item_byte)
  );

  spd_parser #(
    .ADDR_BYTES (ADDR_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .advance   (advance),
    .item_func (item_func),
    .item_byte (item_byte),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  spd_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance && res_valid),
    .res        (res),
    .space      (space),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule
